[hdl/two_segment_color_map_defines.svh]
// Assertion macros used by the colour map top-level design file.
`ifndef TWO_SEGMENT_COLOR_MAP_DEFINES_SVH
`define TWO_SEGMENT_COLOR_MAP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TSCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tscm assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define TSCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tscm assertion failed");

`endif

[hdl/tscm_pkg.sv]
// Package with the shared constants of the two-segment colour map.
package tscm_pkg;

  localparam int unsigned LEVEL_BITS_DEF = 16;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned IDX_W          = 3;
  localparam int unsigned NUM_W          = 40;
  localparam int unsigned DEN_W          = 32;
  localparam int unsigned QUO_W          = 8;

  localparam logic [IDX_W-1:0] REG_MAX   = 3'd0;
  localparam logic [IDX_W-1:0] REG_PEAK  = 3'd1;
  localparam logic [IDX_W-1:0] REG_RED   = 3'd2;
  localparam logic [IDX_W-1:0] REG_GREEN = 3'd3;
  localparam logic [IDX_W-1:0] REG_BLUE  = 3'd4;

  localparam logic [15:0] MAX_RESET   = 16'd255;
  localparam logic [15:0] PEAK_RESET  = 16'd32768;
  localparam logic [7:0]  RED_RESET   = 8'd255;
  localparam logic [7:0]  GREEN_RESET = 8'd0;
  localparam logic [7:0]  BLUE_RESET  = 8'd0;
  localparam logic [7:0]  FULL_CHANNEL = 8'd255;

endpackage

[hdl/tscm_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module tscm_div (
  input  logic                        clk,
  input  logic [tscm_pkg::QUO_W-1:0]  en,
  input  logic [tscm_pkg::NUM_W-1:0]  num,
  input  logic [tscm_pkg::DEN_W-1:0]  den,
  output logic [tscm_pkg::QUO_W-1:0]  quo
);

  localparam int unsigned NW = tscm_pkg::NUM_W;
  localparam int unsigned DW = tscm_pkg::DEN_W;
  localparam int unsigned QW = tscm_pkg::QUO_W;

  logic [NW-1:0] rem  [QW-1];
  logic [DW-1:0] dens [QW-1];
  logic [QW-1:0] qs   [QW];

  genvar s;
  generate
    for (s = 0; s < QW; s++) begin : g_stage
      logic [NW-1:0] rem_in;
      logic [DW-1:0] den_in;
      logic [QW-1:0] q_in;
      logic [NW-1:0] trial;
      logic          fits;

      if (s == 0) begin : g_first
        assign rem_in = num;
        assign den_in = den;
        assign q_in   = '0;
      end else begin : g_rest
        assign rem_in = rem[s-1];
        assign den_in = dens[s-1];
        assign q_in   = qs[s-1];
      end

      // The shifted divisor never overflows since NW covers DW + QW - 1 bits; the quotient is known to fit in QW bits.
      assign trial = NW'(den_in) << (QW - 1 - s);
      assign fits  = rem_in >= trial;

      always_ff @(posedge clk) begin
        if (en[s]) begin
          qs[s] <= q_in | (fits ? (QW'(1) << (QW - 1 - s)) : '0);
        end
      end

      if (s < QW - 1) begin : g_keep
        always_ff @(posedge clk) begin
          if (en[s]) begin
            rem[s]  <= fits ? rem_in - trial : rem_in;
            dens[s] <= den_in;
          end
        end
      end
    end
  endgenerate

  assign quo = qs[QW-1];

endmodule

[hdl/two_segment_color_map.sv]
// Throughput: one beat per cycle while m_axis_tready is high; the eight
// divider stages and the three channel multipliers are fully pipelined,
// and empty stages fill while the output waits. Reset (rst, synchronous)
// empties the pipeline and loads the register defaults; no clearing pass
// is needed.
module two_segment_color_map #(
  parameter int unsigned LEVEL_BITS = tscm_pkg::LEVEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((LEVEL_BITS+7)/8)*8-1:0]   s_axis_tdata,  // level
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata,  // out_blue, out_green, out_red
  output logic                              m_axis_tuser,  // range_error
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tscm_pkg::IDX_W-1:0]        cfg_index,
  input  logic [tscm_pkg::CFG_W-1:0]        cfg_data
);

  localparam int unsigned LW = (LEVEL_BITS > 16) ? LEVEL_BITS : 16;
  localparam int unsigned QW = tscm_pkg::QUO_W;
  localparam int unsigned NS = QW + 4;
  localparam int unsigned D0 = 3;

  logic [15:0] max_value, peak_fraction;
  logic [7:0]  base_red, base_green, base_blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value     <= tscm_pkg::MAX_RESET;
      peak_fraction <= tscm_pkg::PEAK_RESET;
      base_red      <= tscm_pkg::RED_RESET;
      base_green    <= tscm_pkg::GREEN_RESET;
      base_blue     <= tscm_pkg::BLUE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tscm_pkg::REG_MAX:   max_value     <= cfg_data;
        tscm_pkg::REG_PEAK:  peak_fraction <= cfg_data;
        tscm_pkg::REG_RED:   base_red      <= cfg_data[7:0];
        tscm_pkg::REG_GREEN: base_green    <= cfg_data[7:0];
        tscm_pkg::REG_BLUE:  base_blue     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Each stage moves on when it is empty or the stage after it moves on.
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = m_axis_tready | ~vld[NS-1];
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = en[k+1] | ~vld[k];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage A: range check and knee product.
  logic [LW-1:0] lvl_ext;
  logic [15:0]   a_v;
  logic [31:0]   a_knee;
  logic          a_err, a_blk;

  assign lvl_ext = LW'(s_axis_tdata[LEVEL_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_v    <= lvl_ext[15:0];
      a_err  <= lvl_ext > LW'(max_value);
      a_blk  <= lvl_ext >= LW'(max_value);
      a_knee <= 32'(max_value) * 32'(peak_fraction);
    end
  end

  // Stage B: choose segment, operand, divisor and per-channel factor.
  logic [31:0] a_scaled;
  logic        a_low;
  logic [31:0] b_op, b_den;
  logic [7:0]  b_fr, b_fg, b_fb;
  logic        b_low, b_kill, b_err;

  assign a_scaled = {a_v, 16'd0};
  assign a_low    = a_scaled <= a_knee;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_low  <= a_low;
      b_err  <= a_err;
      // Zero knee in the lower segment means level zero, which maps to black.
      b_kill <= a_blk | (a_low & (a_knee == 32'd0));
      b_op   <= a_low ? a_scaled : a_scaled - a_knee;
      b_den  <= a_low ? a_knee : {max_value, 16'd0} - a_knee;
      b_fr   <= a_low ? base_red   : tscm_pkg::FULL_CHANNEL - base_red;
      b_fg   <= a_low ? base_green : tscm_pkg::FULL_CHANNEL - base_green;
      b_fb   <= a_low ? base_blue  : tscm_pkg::FULL_CHANNEL - base_blue;
    end
  end

  // Stage C: numerators.
  logic [tscm_pkg::NUM_W-1:0] c_nr, c_ng, c_nb;
  logic [31:0] c_den;
  logic        c_low, c_kill, c_err;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_nr   <= tscm_pkg::NUM_W'(b_fr) * tscm_pkg::NUM_W'(b_op);
      c_ng   <= tscm_pkg::NUM_W'(b_fg) * tscm_pkg::NUM_W'(b_op);
      c_nb   <= tscm_pkg::NUM_W'(b_fb) * tscm_pkg::NUM_W'(b_op);
      c_den  <= b_den;
      c_low  <= b_low;
      c_kill <= b_kill;
      c_err  <= b_err;
    end
  end

  // Divider stages, with the side information travelling alongside.
  logic [QW-1:0] den_en;
  logic [QW-1:0] q_r, q_g, q_b;
  logic          d_low [QW];
  logic          d_kill [QW];
  logic          d_err [QW];

  assign den_en = en[D0 + QW - 1 : D0];

  tscm_div u_div_r (.clk(clk), .en(den_en), .num(c_nr), .den(c_den), .quo(q_r));
  tscm_div u_div_g (.clk(clk), .en(den_en), .num(c_ng), .den(c_den), .quo(q_g));
  tscm_div u_div_b (.clk(clk), .en(den_en), .num(c_nb), .den(c_den), .quo(q_b));

  always_ff @(posedge clk) begin
    if (den_en[0]) begin
      d_low[0]  <= c_low;
      d_kill[0] <= c_kill;
      d_err[0]  <= c_err;
    end
    for (int k = 1; k < QW; k++) begin
      if (den_en[k]) begin
        d_low[k]  <= d_low[k-1];
        d_kill[k] <= d_kill[k-1];
        d_err[k]  <= d_err[k-1];
      end
    end
  end

  // Output register.
  logic [7:0] o_r, o_g, o_b;
  logic       o_err;

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      o_err <= d_err[QW-1];
      if (d_kill[QW-1]) begin
        o_r <= '0;
        o_g <= '0;
        o_b <= '0;
      end else if (d_low[QW-1]) begin
        o_r <= q_r;
        o_g <= q_g;
        o_b <= q_b;
      end else begin
        o_r <= base_red + q_r;
        o_g <= base_green + q_g;
        o_b <= base_blue + q_b;
      end
    end
  end

  assign m_axis_tvalid = vld[NS-1];
  assign m_axis_tdata  = {o_b, o_g, o_r};
  assign m_axis_tuser  = o_err;

`include "two_segment_color_map_defines.svh"

  `TSCM_ASSERT_NOW(a_err_black, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 24'd0)
  `TSCM_ASSERT_NOW(a_ready_full, !s_axis_tready, vld[NS-1] && !m_axis_tready)
  `TSCM_ASSERT_NEXT(a_out_kept, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

[bench/tb_two_segment_color_map.sv]
// Self-checking bench for the two-segment colour map: reset, extreme and random settings, chosen and random levels.
`timescale 1ns / 1ps
module tb_two_segment_color_map;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       range_err;
  } colour_t;

  // An index that no register answers to.
  localparam logic [tscm_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tscm_pkg::IDX_W-1:0] cfg_index = '0;
  logic [tscm_pkg::CFG_W-1:0] cfg_data = '0;

  two_segment_color_map dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the colour map registers.
  logic [15:0] top_level, knee_frac;
  logic [7:0] main_red, main_green, main_blue;

  logic [15:0] level_queue[$];
  colour_t expected_colours[$];
  int unsigned fail_count = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned idle_count = 0;
  bit calm = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  function automatic logic [7:0] scale_channel(logic [7:0] c, logic [39:0] scaled,
                                               logic [39:0] knee, logic [39:0] span,
                                               bit upper);
    logic [63:0] q;
    if (upper) begin
      q = ((64'd255 - 64'(c)) * 64'(scaled - knee)) / 64'(span);
      return c + q[7:0];
    end
    if (knee == 40'd0) return 8'd0;
    q = (64'(c) * 64'(scaled)) / 64'(knee);
    return q[7:0];
  endfunction

  function automatic colour_t map_level(logic [15:0] v);
    colour_t r;
    logic [39:0] scaled, knee, span;
    bit upper;
    r = '0;
    if (v > top_level) begin
      r.range_err = 1'b1;
    end else if (v != top_level) begin
      scaled = 40'(v) << 16;
      knee = 40'(top_level) * 40'(knee_frac);
      span = 40'(top_level) * (40'd65536 - 40'(knee_frac));
      upper = scaled > knee;
      r.red = scale_channel(main_red, scaled, knee, span, upper);
      r.green = scale_channel(main_green, scaled, knee, span, upper);
      r.blue = scale_channel(main_blue, scaled, knee, span, upper);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_out, what, got, want);
    fail_count++;
  endtask

  // Stream driver.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
    end else begin
      if (s_axis_tvalid) begin
        beats_in++;
        expected_colours.push_back(map_level(s_axis_tdata));
      end
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (level_queue.size() > 0) begin
        s_axis_tdata <= level_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 10);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and back-pressure.
  always @(posedge clk) begin
    colour_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        if (expected_colours.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = expected_colours.pop_front();
          if (m_axis_tdata[7:0] !== want.red) report_mismatch("red", m_axis_tdata[7:0], want.red);
          if (m_axis_tdata[15:8] !== want.green)
            report_mismatch("green", m_axis_tdata[15:8], want.green);
          if (m_axis_tdata[23:16] !== want.blue)
            report_mismatch("blue", m_axis_tdata[23:16], want.blue);
          if (m_axis_tuser !== want.range_err)
            report_mismatch("range_error", m_axis_tuser, want.range_err);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 10);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_count = 0;
      else
        idle_count++;
      if (idle_count > 5000) begin
        $display("Watchdog expired with %0d results pending", expected_colours.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // The valid is dropped before the task waits for its last edge and returns, so that back-to-back
  // writes never touch it twice at the same edge.
  task automatic write_reg(logic [tscm_pkg::IDX_W-1:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    unique case (idx)
      tscm_pkg::REG_MAX:   top_level = val;
      tscm_pkg::REG_PEAK:  knee_frac = val;
      tscm_pkg::REG_RED:   main_red = val[7:0];
      tscm_pkg::REG_GREEN: main_green = val[7:0];
      tscm_pkg::REG_BLUE:  main_blue = val[7:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (level_queue.size() > 0 || s_axis_tvalid || expected_colours.size() > 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic load_setting(logic [15:0] m, logic [15:0] p, logic [7:0] r,
                              logic [7:0] g, logic [7:0] b);
    write_reg(tscm_pkg::REG_MAX, m);
    write_reg(tscm_pkg::REG_PEAK, p);
    write_reg(tscm_pkg::REG_RED, 16'(r));
    write_reg(tscm_pkg::REG_GREEN, 16'(g));
    write_reg(tscm_pkg::REG_BLUE, 16'(b));
  endtask

  // Mostly levels within range, a few at the knee, the top and beyond.
  task automatic queue_random(int n);
    int unsigned k;
    logic [39:0] kn;
    repeat (n) begin
      k = $urandom_range(0, 9);
      kn = (40'(top_level) * 40'(knee_frac)) >> 16;
      if (k == 0) level_queue.push_back(16'($urandom));
      else if (k == 1) level_queue.push_back(top_level);
      else if (k == 2) level_queue.push_back(16'(kn) + 16'($urandom_range(0, 1)));
      else level_queue.push_back(16'($urandom_range(0, 32'(top_level))));
    end
  endtask

  initial begin
    top_level = tscm_pkg::MAX_RESET;
    knee_frac = tscm_pkg::PEAK_RESET;
    main_red = tscm_pkg::RED_RESET;
    main_green = tscm_pkg::GREEN_RESET;
    main_blue = tscm_pkg::BLUE_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Reset defaults: zero, knee, top, above top, all-ones.
    level_queue = '{16'd0, 16'd1, 16'd127, 16'd128, 16'd254, 16'd255, 16'd256, 16'hFFFF};
    drain();
    load_setting(16'hFFFF, 16'hFFFF, 8'd0, 8'd255, 8'd128);
    level_queue = '{16'd0, 16'hFFFE, 16'hFFFF, 16'h8000, 16'h5555};
    drain();
    load_setting(16'd1, 16'd1, 8'd255, 8'd255, 8'd255);
    level_queue = '{16'd0, 16'd1, 16'd2, 16'hAAAA};
    drain();
    // An unknown register index leaves the settings alone; the next load rewrites every register anyway.
    write_reg(REG_UNUSED, 16'h1234);
    load_setting(16'd0, 16'd100, 8'd10, 8'd20, 8'd30);
    level_queue = '{16'd0, 16'd1, 16'd300};
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      load_setting(ph == 0 ? 16'd65535 : (ph == 1 ? 16'd1 : 16'($urandom_range(1, 65535))),
                   ph == 2 ? 16'd1 : (ph == 3 ? 16'd65535 : 16'($urandom_range(1, 65535))),
                   8'($urandom), 8'($urandom), 8'($urandom));
      calm = (ph == 5);
      queue_random(105);
      drain();
    end
    $display("Covered %0d levels across reset, extreme and random settings,", beats_in);
    $display("with random stalls on both streams and %0d results checked.", beats_out);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
